// File: rtl/u256_pkg.sv
// shared types, operation codes and sizing constants for the 256-bit alu
package u256_pkg;

   // operation codes
   localparam logic [2:0] FN_ADD     = 3'd0;
   localparam logic [2:0] FN_SUB     = 3'd1;
   localparam logic [2:0] FN_MUL_LO  = 3'd2;
   localparam logic [2:0] FN_MUL_FULL = 3'd3;
   localparam logic [2:0] FN_DIVMOD  = 3'd4;
   localparam logic [2:0] FN_SHL     = 3'd5;
   localparam logic [2:0] FN_SHR     = 3'd6;

   // default queue depths
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   // classified request as it travels from front to back
   typedef struct packed {
      logic [2:0]   func;
      logic         long_op;
      logic         b_zero;
      logic [7:0]   shamt;
      logic [255:0] a;
      logic [255:0] b;
   } cmd_type;

   // finished result
   typedef struct packed {
      logic [255:0] r;
      logic [255:0] x;
      logic         flag;
   } rsp_type;

endpackage

// File: rtl/u256_fifo.sv
// small register queue with first-word fall-through read
module u256_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == DEPTH[AW:0]);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: rtl/u256_front.sv
// request front end: packs operands and classifies the operation
module u256_front (
   input  logic              req_push,
   output logic              req_full,
   input  logic [2:0]        req_func,
   input  logic [63:0]       req_a_word0,
   input  logic [63:0]       req_a_word1,
   input  logic [63:0]       req_a_word2,
   input  logic [63:0]       req_a_word3,
   input  logic [63:0]       req_b_word0,
   input  logic [63:0]       req_b_word1,
   input  logic [63:0]       req_b_word2,
   input  logic [63:0]       req_b_word3,
   input  logic [7:0]        req_shift_amount,
   output u256_pkg::cmd_type cmd,
   output logic              cmd_push,
   input  logic              cmd_full
);
   import u256_pkg::*;

   // classify and pack
   always_comb begin
      cmd.func    = req_func;
      cmd.long_op = (req_func inside {FN_MUL_LO, FN_MUL_FULL, FN_DIVMOD});
      cmd.a       = {req_a_word3, req_a_word2, req_a_word1, req_a_word0};
      cmd.b       = {req_b_word3, req_b_word2, req_b_word1, req_b_word0};
      cmd.b_zero  = (cmd.b == '0);
      cmd.shamt   = req_shift_amount;
   end

   assign cmd_push = req_push;
   assign req_full = cmd_full;

endmodule

// File: rtl/u256_back.sv
// execution back end: combinational ops plus iterative multiply and divide
module u256_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  u256_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output u256_pkg::rsp_type rsp
);
   import u256_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]   state_ff, state_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic [2:0]   func_ff, func_in;
   logic [255:0] a_ff, a_in;
   logic [255:0] b_ff, b_in;
   logic [511:0] acc_ff, acc_in;
   logic [63:0]  prod_ff, prod_in;
   logic [3:0]   pos_ff, pos_in;
   logic         pv_ff, pv_in;

   logic [256:0] add_sum;
   logic [256:0] sub_dif;
   logic [2:0]   mi, mj;
   logic [31:0]  ma, mb;
   logic [511:0] pp;
   logic [256:0] dsh;
   logic [257:0] ddif;
   rsp_type      fast;

   // combinational operations
   always_comb begin
      add_sum   = {1'b0, cmd.a} + {1'b0, cmd.b};
      sub_dif   = {1'b0, cmd.a} - {1'b0, cmd.b};
      fast      = '0;
      case (cmd.func)
         FN_ADD: begin
            fast.r    = add_sum[255:0];
            fast.flag = add_sum[256];
         end
         FN_SUB: begin
            fast.r    = sub_dif[255:0];
            fast.flag = sub_dif[256];
         end
         FN_DIVMOD: begin
            fast.flag = 1'b1;
         end
         FN_SHL: fast.r = cmd.a << cmd.shamt;
         FN_SHR: fast.r = cmd.a >> cmd.shamt;
         default: fast = '0;
      endcase
   end

   // one 32x32 partial product per cycle
   always_comb begin
      mi      = cnt_ff[5:3];
      mj      = cnt_ff[2:0];
      ma      = a_ff[{mi, 5'd0} +: 32];
      mb      = b_ff[{mj, 5'd0} +: 32];
      prod_in = {32'd0, ma} * {32'd0, mb};
      pos_in  = {1'b0, mi} + {1'b0, mj};
      pp      = {448'd0, prod_ff} << {pos_ff, 5'd0};
   end

   // one restoring divide step: remainder high, quotient low in the accumulator
   always_comb begin
      dsh  = {acc_ff[511:256], acc_ff[255]};
      ddif = {1'b0, dsh} - {2'b00, b_ff};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      func_in  = func_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      pv_in    = 1'b0;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp      = fast;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (!cmd.long_op || (cmd.func == FN_DIVMOD && cmd.b_zero)) begin
                  if (!rsp_full) begin
                     cmd_pop  = 1'b1;
                     rsp_push = 1'b1;
                  end
               end else begin
                  cmd_pop = 1'b1;
                  func_in = cmd.func;
                  a_in    = cmd.a;
                  b_in    = cmd.b;
                  cnt_in  = '0;
                  if (cmd.func == FN_DIVMOD) begin
                     acc_in   = {256'd0, cmd.a};
                     state_in = ST_DIV;
                  end else begin
                     acc_in   = '0;
                     state_in = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            if (pv_ff) begin
               acc_in = acc_ff + pp;
            end
            if (cnt_ff == 8'd64) begin
               state_in = ST_FIN;
            end else begin
               pv_in  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (ddif[257]) begin
               acc_in = {dsh[255:0], acc_ff[254:0], 1'b0};
            end else begin
               acc_in = {ddif[255:0], acc_ff[254:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 8'd255) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            rsp.r    = acc_ff[255:0];
            rsp.x    = acc_ff[511:256];
            rsp.flag = 1'b0;
            if (func_ff == FN_MUL_LO) begin
               rsp.x    = '0;
               rsp.flag = |acc_ff[511:256];
            end
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      pos_ff  <= pos_in;
   end

endmodule

// File: rtl/uint256_arith_unit_core.sv
// top level of the 256-bit unsigned integer alu
//
// Requests enter through a queue-style port: drive the operands and
// req_func, raise req_push, and the request is taken at an edge where
// req_full is low. Results leave the same way: while rsp_empty is low the
// oldest result sits on the rsp_ ports and is taken at an edge with rsp_pop.
// The front end classifies each request into a command queue; the back end
// executes commands strictly in order into a result queue.
// Add, sub, shifts, unused codes and divide by zero finish in the back end's
// idle state, so they stream at one request per cycle while the result
// queue has room. Multiply runs one 32x32 partial product per cycle.
// Divide retires one quotient bit per cycle. While a multiply or divide is
// in the back end, later requests wait in the command queue. When the
// receiver holds off rsp_pop, the result queue fills, the back end stops
// and the command queue then raises req_full.
// Synchronous reset empties both queues and returns the back end to idle.
module uint256_arith_unit_core #(
   parameter int CMD_DEPTH = u256_pkg::CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = u256_pkg::RSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_a_word0,
   input  logic [63:0] req_a_word1,
   input  logic [63:0] req_a_word2,
   input  logic [63:0] req_a_word3,
   input  logic [63:0] req_b_word0,
   input  logic [63:0] req_b_word1,
   input  logic [63:0] req_b_word2,
   input  logic [63:0] req_b_word3,
   input  logic [7:0]  req_shift_amount,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_r_word0,
   output logic [63:0] rsp_r_word1,
   output logic [63:0] rsp_r_word2,
   output logic [63:0] rsp_r_word3,
   output logic [63:0] rsp_x_word0,
   output logic [63:0] rsp_x_word1,
   output logic [63:0] rsp_x_word2,
   output logic [63:0] rsp_x_word3,
   output logic        rsp_error_flag
);
   import u256_pkg::*;

   cmd_type fe_cmd, q_cmd;
   rsp_type be_rsp, q_rsp;
   logic    fe_push, cmdq_full, cmdq_empty, be_pop;
   logic    be_push, rspq_full;

   // front end
   u256_front u_front (
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_a_word0      (req_a_word0),
      .req_a_word1      (req_a_word1),
      .req_a_word2      (req_a_word2),
      .req_a_word3      (req_a_word3),
      .req_b_word0      (req_b_word0),
      .req_b_word1      (req_b_word1),
      .req_b_word2      (req_b_word2),
      .req_b_word3      (req_b_word3),
      .req_shift_amount (req_shift_amount),
      .cmd              (fe_cmd),
      .cmd_push         (fe_push),
      .cmd_full         (cmdq_full)
   );

   // command queue between front and back
   u256_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (fe_push),
      .din   (fe_cmd),
      .full  (cmdq_full),
      .pop   (be_pop),
      .dout  (q_cmd),
      .empty (cmdq_empty)
   );

   // back end
   u256_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmdq_empty),
      .cmd       (q_cmd),
      .cmd_pop   (be_pop),
      .rsp_full  (rspq_full),
      .rsp_push  (be_push),
      .rsp       (be_rsp)
   );

   // result queue
   u256_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (be_push),
      .din   (be_rsp),
      .full  (rspq_full),
      .pop   (rsp_pop),
      .dout  (q_rsp),
      .empty (rsp_empty)
   );

   assign rsp_r_word0    = q_rsp.r[63:0];
   assign rsp_r_word1    = q_rsp.r[127:64];
   assign rsp_r_word2    = q_rsp.r[191:128];
   assign rsp_r_word3    = q_rsp.r[255:192];
   assign rsp_x_word0    = q_rsp.x[63:0];
   assign rsp_x_word1    = q_rsp.x[127:64];
   assign rsp_x_word2    = q_rsp.x[191:128];
   assign rsp_x_word3    = q_rsp.x[255:192];
   assign rsp_error_flag = q_rsp.flag;

endmodule
